// ----- hw/rtl/tccs_pkg.sv -----
`timescale 1ns / 1ps

package tccs_pkg;

   typedef enum logic [1:0] {
      OP_PUT  = 2'd0,
      OP_SET  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   localparam logic [7:0] CODE_LF = 8'd10;
   localparam logic [7:0] CODE_VT = 8'd11;
   localparam logic [7:0] CODE_CR = 8'd13;

   localparam int CODE_W   = 8;
   localparam int COORD_W  = 5;
   localparam int SCROLL_W = 2;

endpackage

// ----- hw/rtl/tccs_ram.sv -----
`timescale 1ns / 1ps

module tccs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 640
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/text_console_cursor_scroll.sv -----
`timescale 1ns / 1ps

// Channel   Handshake               Ports
// request   start & !busy           req_opcode req_char_code req_col req_row
// response  rsp_valid, one cycle    rsp_cursor_col rsp_cursor_row rsp_cell_value
//
// A put that does not scroll, set cursor and the unused opcode give a registered response; busy stays low.
// Read cell raises busy for S_READ: one registered read of the map RAM, then a registered response.
// A put that scrolls sweeps the whole map once per scroll, for n scrolls (1 to 3),
// one RAM cell copied or cleared per cycle through the single write port.
// After reset, busy is high while the map is cleared.
// The receiver cannot stall: each response is shown for exactly one cycle.

module text_console_cursor_scroll
   import tccs_pkg::*;
#(
   parameter int COLUMNS    = 30,
   parameter int ROWS       = 20,
   parameter int ROW_STRIDE = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [CODE_W-1:0]  req_char_code,
   input  logic [COORD_W-1:0] req_col,
   input  logic [COORD_W-1:0] req_row,
   output logic               rsp_valid,
   output logic [COORD_W-1:0] rsp_cursor_col,
   output logic [COORD_W-1:0] rsp_cursor_row,
   output logic [CODE_W-1:0]  rsp_cell_value
);

   localparam int MAP_CELLS  = ROWS * ROW_STRIDE;
   localparam int COPY_CELLS = (ROWS - 1) * ROW_STRIDE;
   localparam int AW         = $clog2(MAP_CELLS);
   localparam int CW         = $clog2(MAP_CELLS + 64);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SWEEP,
      S_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [SCROLL_W-1:0]   scroll_ff, scroll_in;
   logic                  clear_ff, clear_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic                  pend_copy_ff, pend_copy_in;
   logic [COORD_W-1:0]    cursor_x_ff, cursor_x_in;
   logic [COORD_W-1:0]    cursor_y_ff, cursor_y_in;
   logic                  rd_zero_ff, rd_zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [COORD_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [CODE_W-1:0]     rsp_value_ff, rsp_value_in;

   logic                  accept;
   logic [CW-1:0]         put_addr;
   logic                  put_ok;
   logic [COORD_W:0]      x_inc;
   logic                  wrap;
   logic                  is_vt, is_cr;
   logic [COORD_W:0]      y_total;
   logic [COORD_W:0]      last_row;
   logic [COORD_W-1:0]    put_x, put_y;
   logic [SCROLL_W-1:0]   put_scrolls;
   logic [CW-1:0]         read_addr;
   logic                  read_ok;
   logic [CW-1:0]         sweep_rd;
   logic                  copy_now;

   logic                  ram_we;
   logic [AW-1:0]         ram_wr_addr;
   logic [CODE_W-1:0]     ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [CODE_W-1:0]     ram_rd_data;

   tccs_ram #(
      .WIDTH(CODE_W),
      .DEPTH(MAP_CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // put character
   assign put_addr = CW'(cursor_y_ff) * CW'(ROW_STRIDE) + CW'(cursor_x_ff);
   assign put_ok   = put_addr < CW'(MAP_CELLS);
   assign x_inc    = {1'b0, cursor_x_ff} + (COORD_W+1)'(1);
   assign wrap     = (x_inc >= (COORD_W+1)'(COLUMNS)) || (req_char_code == CODE_LF);
   assign is_vt    = (req_char_code == CODE_VT);
   assign is_cr    = (req_char_code == CODE_CR);
   assign last_row = (COORD_W+1)'(ROWS - 1);
   assign y_total  = {1'b0, cursor_y_ff} + (COORD_W+1)'(wrap)
                   + (is_vt ? (COORD_W+1)'(2) : (is_cr ? (COORD_W+1)'(1) : '0));
   assign put_x    = (wrap || is_cr) ? '0 : x_inc[COORD_W-1:0];

   always_comb begin
      if (y_total > last_row) begin
         put_y       = last_row[COORD_W-1:0];
         put_scrolls = SCROLL_W'(y_total - last_row);
      end else begin
         put_y       = y_total[COORD_W-1:0];
         put_scrolls = '0;
      end
   end

   // read cell
   assign read_addr = CW'(req_row) * CW'(ROW_STRIDE) + CW'(req_col);
   assign read_ok   = ({1'b0, req_col} < (COORD_W+1)'(COLUMNS))
                   && ({1'b0, req_row} < (COORD_W+1)'(ROWS))
                   && (read_addr < CW'(MAP_CELLS));

   // scroll / clear sweep: read one row ahead, write in the following cycle
   assign sweep_rd = CW'(idx_ff) + CW'(ROW_STRIDE);
   assign copy_now = !clear_ff && (CW'(idx_ff) < CW'(COPY_CELLS));

   assign ram_rd_addr = (state_ff == S_IDLE) ? AW'(read_addr) : AW'(sweep_rd);
   assign ram_we      = pend_ff || (accept && (req_opcode == OP_PUT) && put_ok);
   assign ram_wr_addr = pend_ff ? pend_addr_ff : AW'(put_addr);
   assign ram_wr_data = pend_ff ? (pend_copy_ff ? ram_rd_data : '0) : req_char_code;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      scroll_in    = scroll_ff;
      clear_in     = clear_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      pend_copy_in = pend_copy_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      rd_zero_in   = rd_zero_ff;
      rsp_valid_in = 1'b0;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_value_in = rsp_value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in = '0;
               rsp_col_in   = cursor_x_ff;
               rsp_row_in   = cursor_y_ff;
               unique case (opcode_type'(req_opcode))
                  OP_PUT: begin
                     cursor_x_in = put_x;
                     cursor_y_in = put_y;
                     rsp_col_in  = put_x;
                     rsp_row_in  = put_y;
                     if (put_scrolls != '0) begin
                        scroll_in = put_scrolls;
                        idx_in    = '0;
                        clear_in  = 1'b0;
                        state_in  = S_SWEEP;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_SET: begin
                     if (({1'b0, req_col} < (COORD_W+1)'(COLUMNS))
                         && ({1'b0, req_row} < (COORD_W+1)'(ROWS))) begin
                        cursor_x_in = req_col;
                        cursor_y_in = req_row;
                        rsp_col_in  = req_col;
                        rsp_row_in  = req_row;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_READ: begin
                     rd_zero_in = !read_ok;
                     state_in   = S_READ;
                  end
                  OP_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_value_in = rd_zero_ff ? '0 : ram_rd_data;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SWEEP: begin
            pend_in      = 1'b1;
            pend_addr_in = idx_ff;
            pend_copy_in = copy_now;
            if (idx_ff == AW'(MAP_CELLS - 1)) begin
               idx_in = '0;
               if (!clear_ff && (scroll_ff > SCROLL_W'(1))) begin
                  scroll_in = scroll_ff - SCROLL_W'(1);
               end else begin
                  state_in = S_FLUSH;
               end
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_FLUSH: begin
            rsp_valid_in = !clear_ff;
            clear_in     = 1'b0;
            state_in     = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         idx_ff       <= '0;
         scroll_ff    <= SCROLL_W'(1);
         clear_ff     <= 1'b1;
         pend_ff      <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         scroll_ff    <= scroll_in;
         clear_ff     <= clear_in;
         pend_ff      <= pend_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_addr_ff <= pend_addr_in;
      pend_copy_ff <= pend_copy_in;
      rd_zero_ff   <= rd_zero_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_value = rsp_value_ff;

endmodule

// ----- tb/sv/tb_text_console_cursor_scroll.sv -----
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;
   import tccs_pkg::*;

   localparam int COLUMNS    = 30;
   localparam int ROWS       = 20;
   localparam int ROW_STRIDE = 32;
   localparam int MAP_CELLS  = ROWS * ROW_STRIDE;
   localparam int RANDOM_REQUESTS = 1150;

   typedef struct {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [CODE_W-1:0]  value;
   } cursor_report_type;

   class console_tracker_type;
      logic [CODE_W-1:0] cells [MAP_CELLS];
      int unsigned       cur_x;
      int unsigned       cur_y;
      cursor_report_type pending_reports [$];
      int                errors;

      function new();
         cur_x  = 0;
         cur_y  = 0;
         errors = 0;
         foreach (cells[i]) cells[i] = '0;
      endfunction

      function void scroll_map();
         for (int i = 0; i < (ROWS - 1) * ROW_STRIDE; i++) cells[i] = cells[i + ROW_STRIDE];
         for (int i = (ROWS - 1) * ROW_STRIDE; i < MAP_CELLS; i++) cells[i] = '0;
      endfunction

      function int unsigned settle_row(int unsigned y);
         while (y >= ROWS) begin
            scroll_map();
            y--;
         end
         return y;
      endfunction

      function void take_request(opcode_type op, logic [CODE_W-1:0] code,
                                 logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
         cursor_report_type rep;
         int unsigned       addr;
         rep.value = '0;
         case (op)
            OP_PUT: begin
               addr = cur_y * ROW_STRIDE + cur_x;
               if (addr < MAP_CELLS) cells[addr] = code;
               cur_x++;
               if (cur_x >= COLUMNS || code == CODE_LF) begin
                  cur_x = 0;
                  cur_y = settle_row(cur_y + 1);
               end
               if (code == CODE_VT) begin
                  cur_y = settle_row(cur_y + 2);
               end else if (code == CODE_CR) begin
                  cur_x = 0;
                  cur_y = settle_row(cur_y + 1);
               end
            end
            OP_SET: begin
               if (c < COLUMNS && r < ROWS) begin
                  cur_x = 32'(c);
                  cur_y = 32'(r);
               end
            end
            OP_READ: begin
               addr = r * ROW_STRIDE + c;
               if (c < COLUMNS && r < ROWS && addr < MAP_CELLS) rep.value = cells[addr];
            end
            default: begin
            end
         endcase
         rep.col = cur_x[COORD_W-1:0];
         rep.row = cur_y[COORD_W-1:0];
         pending_reports.push_back(rep);
      endfunction

      function void compare_report(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                   logic [CODE_W-1:0] value);
         cursor_report_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t unexpected response col %0d row %0d value %0d", $time, col, row, value);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         if (want.col !== col) begin
            $display("%0t cursor_col expected %0d actual %0d", $time, want.col, col);
            errors++;
         end
         if (want.row !== row) begin
            $display("%0t cursor_row expected %0d actual %0d", $time, want.row, row);
            errors++;
         end
         if (want.value !== value) begin
            $display("%0t cell_value expected %0d actual %0d", $time, want.value, value);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = '0;
   logic [CODE_W-1:0]  req_char_code = '0;
   logic [COORD_W-1:0] req_col = '0;
   logic [COORD_W-1:0] req_row = '0;
   logic               rsp_valid;
   logic [COORD_W-1:0] rsp_cursor_col;
   logic [COORD_W-1:0] rsp_cursor_row;
   logic [CODE_W-1:0]  rsp_cell_value;

   console_tracker_type tracker = new();

   text_console_cursor_scroll #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .ROW_STRIDE(ROW_STRIDE)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_col       (req_col),
      .req_row       (req_row),
      .rsp_valid     (rsp_valid),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_value(rsp_cell_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && start && busy === 1'b0) begin
         tracker.take_request(opcode_type'(req_opcode), req_char_code, req_col, req_row);
      end
      if (!reset && rsp_valid === 1'b1) begin
         tracker.compare_report(rsp_cursor_col, rsp_cursor_row, rsp_cell_value);
      end
   end

   task automatic send_request(opcode_type op, logic [CODE_W-1:0] code,
                               logic [COORD_W-1:0] c, logic [COORD_W-1:0] r, bit idle);
      start         <= 1'b1;
      req_opcode    <= op;
      req_char_code <= code;
      req_col       <= c;
      req_row       <= r;
      do @(posedge clock); while (busy !== 1'b0);
      if (idle) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending_reports.size() != 0) @(posedge clock);
   endtask

   initial begin
      int                 n;
      int                 pick;
      opcode_type         op;
      logic [CODE_W-1:0]  code;
      logic [COORD_W-1:0] c;
      logic [COORD_W-1:0] r;
      bit                 idle;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_READ, 8'hFF, 5'd0, 5'd0, 1'b0);
      send_request(OP_READ, 8'h00, 5'd31, 5'd31, 1'b0);
      send_request(OP_SET, 8'h00, COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 1), 1'b0);
      send_request(OP_PUT, 8'h41, 5'd0, 5'd0, 1'b0);
      send_request(OP_READ, 8'h00, COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 2), 1'b0);
      send_request(OP_SET, 8'h00, COORD_W'(COLUMNS), 5'd5, 1'b0);
      send_request(OP_SET, 8'h00, 5'd5, COORD_W'(ROWS), 1'b0);
      send_request(OP_SET, 8'h00, COORD_W'(COLUMNS - 2), COORD_W'(ROWS - 1), 1'b0);
      send_request(OP_PUT, CODE_CR, 5'd0, 5'd0, 1'b0);
      send_request(OP_SET, 8'h00, COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 1), 1'b0);
      send_request(OP_PUT, CODE_CR, 5'd31, 5'd31, 1'b0);
      send_request(OP_SET, 8'h00, COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 1), 1'b0);
      send_request(OP_PUT, CODE_VT, 5'd0, 5'd0, 1'b0);
      send_request(OP_PUT, CODE_LF, 5'd0, 5'd0, 1'b0);
      send_request(OP_SET, 8'h00, 5'd0, 5'd0, 1'b0);
      send_request(OP_PUT, 8'h00, 5'd0, 5'd0, 1'b0);
      send_request(OP_PUT, 8'hFF, 5'd0, 5'd0, 1'b0);
      send_request(OP_READ, 8'h00, 5'd0, 5'd0, 1'b0);
      send_request(OP_READ, 8'h00, 5'd1, 5'd0, 1'b0);
      send_request(OP_SET, 8'h00, 5'd10, 5'd5, 1'b0);
      send_request(OP_PUT, CODE_VT, 5'd0, 5'd0, 1'b0);
      send_request(OP_PUT, CODE_LF, 5'd0, 5'd0, 1'b0);
      send_request(OP_NONE, 8'hFF, 5'd31, 5'd31, 1'b0);
      send_request(OP_READ, 8'h00, COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 1), 1'b0);
      send_request(OP_READ, 8'h00, COORD_W'(COLUMNS), 5'd0, 1'b0);
      wait_drained();

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         c    = COORD_W'($urandom_range(0, 31));
         r    = COORD_W'($urandom_range(0, 31));
         code = CODE_W'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            op   = OP_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               code = CODE_W'($urandom_range(32, 126));
            end else if (pick >= 88) begin
               case ($urandom_range(0, 2))
                  0:       code = CODE_LF;
                  1:       code = CODE_VT;
                  default: code = CODE_CR;
               endcase
            end
         end else if (pick < 70) begin
            op = OP_SET;
            if ($urandom_range(0, 99) < 80) begin
               c = COORD_W'($urandom_range(0, COLUMNS - 1));
               r = COORD_W'(($urandom_range(0, 3) == 0) ? ROWS - 1
                                                        : $urandom_range(0, ROWS - 1));
            end
         end else if (pick < 95) begin
            op = OP_READ;
            if ($urandom_range(0, 99) < 85) begin
               c = COORD_W'($urandom_range(0, COLUMNS - 1));
               r = COORD_W'($urandom_range(0, ROWS - 1));
            end
         end else begin
            op = OP_NONE;
         end
         // requests 300 to 549: back-to-back requests, no random idle gaps apart from the drain after request 399
         idle = !(n >= 300 && n < 550) && ($urandom_range(0, 99) < 17);
         if (n % 200 == 199) begin
            send_request(op, code, c, r, 1'b0);
            wait_drained();
         end else begin
            send_request(op, code, c, r, idle);
         end
      end

      wait_drained();
      repeat (3 * MAP_CELLS + 8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
         $display("tb_text_console_cursor_scroll passed");
      end else begin
         $display("tb_text_console_cursor_scroll failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_text_console_cursor_scroll failed");
      $finish;
   end

endmodule
